### sv/ket_pkg.sv
package ket_pkg;

  localparam int unsigned HeadW = 64;
  localparam int unsigned TailW = 48;
  localparam int unsigned KeyW  = HeadW + TailW;
  localparam int unsigned EntW  = 2 * KeyW;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LIST   = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_NONE  = 2'd2,
    ST_ENTRY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_WRITE,
    S_FINAL,
    S_FLUSH
  } state_e;

  // one queued command between front and back
  typedef struct packed {
    cmd_e             cmd;
    logic             key_zero;
    logic [KeyW-1:0]  key;
    logic [KeyW-1:0]  value;
  } cmd_t;

endpackage

### sv/keyed_entry_table_unit.sv
// Channel   Valid     Stall     Payload
// command   valid_i   stall_o   cmd_i, key_*_i, value_*_i
// result    valid_o   stall_i   status_o, slot_index_o, out_*_o, removed_count_o, last_o
//
// After reset a clearing pass writes zero to every slot, and no command
// runs until it ends (commands still queue, two deep).
// Each command scans the table one slot per cycle through the single
// RAM read port.
// A stalled result holds the scan; a zero-key insert skips the scan.
module keyed_entry_table_unit #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [63:0] key_head_i,
  input  logic [47:0] key_tail_i,
  input  logic [63:0] value_head_i,
  input  logic [47:0] value_tail_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [1:0]  status_o,
  output logic [5:0]  slot_index_o,
  output logic [63:0] out_key_head_o,
  output logic [47:0] out_key_tail_o,
  output logic [63:0] out_value_head_o,
  output logic [47:0] out_value_tail_o,
  output logic [6:0]  removed_count_o,
  output logic        last_o
);
  import ket_pkg::*;

  logic q_valid, q_pop;
  cmd_t q_cmd;

  ket_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .cmd_i, .key_head_i, .key_tail_i,
    .value_head_i, .value_tail_i,
    .q_valid_o (q_valid), .q_pop_i (q_pop), .q_cmd_o (q_cmd)
  );

  ket_back #(.Depth(DEPTH)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid), .q_pop_o (q_pop), .q_cmd_i (q_cmd),
    .valid_o, .stall_i, .status_o, .slot_index_o, .out_key_head_o,
    .out_key_tail_o, .out_value_head_o, .out_value_tail_o,
    .removed_count_o, .last_o
  );

endmodule

### sv/ket_ram.sv
module ket_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### sv/ket_front.sv
// Accepts commands, flags zero keys, and holds them in a
// two-deep queue for the back end.
module ket_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic [1:0]                cmd_i,
  input  logic [63:0]               key_head_i,
  input  logic [47:0]               key_tail_i,
  input  logic [63:0]               value_head_i,
  input  logic [47:0]               value_tail_i,
  output logic                      q_valid_o,
  input  logic                      q_pop_i,
  output ket_pkg::cmd_t             q_cmd_o
);
  import ket_pkg::*;

  cmd_t       buf_q [2];
  logic       rd_q, wr_q;
  logic [1:0] cnt_q;
  cmd_t       item;
  logic       push;

  always_comb begin
    item.cmd      = cmd_e'(cmd_i);
    item.key      = {key_head_i, key_tail_i};
    item.value    = {value_head_i, value_tail_i};
    item.key_zero = (item.key == '0);
  end

  assign stall_o   = (cnt_q == 2'd2);
  assign push      = valid_i && !stall_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o   = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> q_valid_o) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !q_pop_i) else $error("pop while empty");

endmodule

### sv/ket_back.sv
// Scans the table one slot per cycle (a hit can stall on a held result) and produces result items.
module ket_back #(
  parameter int unsigned Depth = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_pop_o,
  input  ket_pkg::cmd_t  q_cmd_i,
  output logic           valid_o,
  input  logic           stall_i,
  output logic [1:0]     status_o,
  output logic [5:0]     slot_index_o,
  output logic [63:0]    out_key_head_o,
  output logic [47:0]    out_key_tail_o,
  output logic [63:0]    out_value_head_o,
  output logic [47:0]    out_value_tail_o,
  output logic [6:0]     removed_count_o,
  output logic           last_o
);
  import ket_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  state_e         state_q, state_d;
  logic [AW:0]    addr_q, addr_d;     // read address, one bit wider than the RAM address
  logic [AW:0]    chk_q, chk_d;       // slot whose data is on rdata
  logic           chk_v_q, chk_v_d;
  logic [CW-1:0]  count_q, count_d;
  logic           free_found_q, free_found_d;
  logic [AW-1:0]  free_slot_q, free_slot_d;

  // pending hit held until the next hit or the end decides last
  logic           pend_v_q, pend_v_d;
  logic [AW-1:0]  pend_slot_q, pend_slot_d;
  logic [EntW-1:0] pend_ent_q, pend_ent_d;

  // output register
  logic           ov_q, ov_d;
  logic [1:0]     ost_q, ost_d;
  logic [5:0]     oslot_q, oslot_d;
  logic [EntW-1:0] oent_q, oent_d;
  logic [6:0]     ocnt_q, ocnt_d;
  logic           olast_q, olast_d;

  logic           we;
  logic [AW-1:0]  waddr;
  logic [EntW-1:0] wdata, rdata;
  logic [AW-1:0]  raddr;
  logic           used, match, hit, out_free;

  ket_ram #(.Width(EntW), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign raddr    = addr_q[AW-1:0];
  assign used     = (rdata[EntW-1 -: KeyW] != '0);
  assign match    = (rdata[EntW-1 -: KeyW] == q_cmd_i.key);
  assign out_free = !ov_q || !stall_i;

  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    chk_d        = chk_q;
    chk_v_d      = 1'b0;
    count_d      = count_q;
    free_found_d = free_found_q;
    free_slot_d  = free_slot_q;
    pend_v_d     = pend_v_q;
    pend_slot_d  = pend_slot_q;
    pend_ent_d   = pend_ent_q;
    ov_d         = ov_q && stall_i;
    ost_d        = ost_q;
    oslot_d      = oslot_q;
    oent_d       = oent_q;
    ocnt_d       = ocnt_q;
    olast_d      = olast_q;
    we           = 1'b0;
    waddr        = chk_q[AW-1:0];
    wdata        = '0;
    q_pop_o      = 1'b0;
    hit          = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = addr_q[AW-1:0];
        addr_d = addr_q + 1'b1;
        if (addr_q == (AW+1)'(Depth - 1)) begin
          state_d = S_IDLE;
          addr_d  = '0;
        end
      end
      S_IDLE: begin
        if (q_valid_i) begin
          if (q_cmd_i.cmd == CMD_INSERT && q_cmd_i.key_zero) begin
            state_d = S_FINAL;
          end else begin
            state_d = S_SCAN;
            addr_d  = (AW+1)'(1);
            chk_d   = '0;
            chk_v_d = 1'b1;
          end
          count_d      = '0;
          free_found_d = 1'b0;
          pend_v_d     = 1'b0;
        end
      end
      S_SCAN: begin
        // scan stalls only when a hit must move the pending entry out while the output register is held
        if (chk_v_q) begin
          unique case (q_cmd_i.cmd)
            CMD_INSERT: hit = 1'b0;
            CMD_LIST:   hit = used;
            CMD_FIND:   hit = used && match;
            CMD_DELETE: hit = !q_cmd_i.key_zero && match;
            default:    hit = 1'b0;
          endcase
        end
        if (hit && pend_v_q && !out_free) begin
          // replay this slot: point the read back at it
          chk_v_d = 1'b0;
          addr_d  = chk_q;
        end else begin
          if (chk_v_q) begin
            if (q_cmd_i.cmd == CMD_INSERT && !used && !free_found_q) begin
              free_found_d = 1'b1;
              free_slot_d  = chk_q[AW-1:0];
            end
            if (hit && q_cmd_i.cmd == CMD_DELETE) begin
              we      = 1'b1;
              count_d = count_q + 1'b1;
            end
            if (hit && (q_cmd_i.cmd == CMD_LIST || q_cmd_i.cmd == CMD_FIND)) begin
              if (pend_v_q) begin
                ov_d    = 1'b1;
                ost_d   = ST_ENTRY;
                oslot_d = 6'(pend_slot_q);
                oent_d  = pend_ent_q;
                ocnt_d  = '0;
                olast_d = 1'b0;
              end
              pend_v_d    = 1'b1;
              pend_slot_d = chk_q[AW-1:0];
              pend_ent_d  = rdata;
            end
          end
          if (chk_v_q && chk_q == (AW+1)'(Depth - 1)) begin
            state_d = (q_cmd_i.cmd == CMD_INSERT && (free_found_q || !used))
                      ? S_WRITE : S_FINAL;
          end else begin
            chk_d   = addr_q;
            chk_v_d = 1'b1;
            addr_d  = addr_q + 1'b1;
          end
        end
        // keep the RAM address in range
        if (addr_d[AW-1:0] == '0 && addr_d != '0) addr_d = '0;
      end
      S_WRITE: begin
        we    = 1'b1;
        waddr = free_slot_q;
        wdata = {q_cmd_i.key, q_cmd_i.value};
        state_d = S_FINAL;
      end
      S_FINAL: begin
        if (out_free) begin
          ov_d    = 1'b1;
          olast_d = 1'b1;
          oslot_d = '0;
          oent_d  = '0;
          ocnt_d  = '0;
          unique case (q_cmd_i.cmd)
            CMD_INSERT: begin
              if (q_cmd_i.key_zero) begin
                ost_d = ST_DONE;
              end else if (free_found_q) begin
                ost_d   = ST_DONE;
                oslot_d = 6'(free_slot_q);
              end else begin
                ost_d = ST_FULL;
              end
            end
            CMD_DELETE: begin
              ost_d  = (count_q != '0) ? ST_DONE : ST_NONE;
              ocnt_d = 7'(count_q);
            end
            default: begin
              if (pend_v_q) begin
                ost_d   = ST_ENTRY;
                oslot_d = 6'(pend_slot_q);
                oent_d  = pend_ent_q;
              end else begin
                ost_d = ST_NONE;
              end
            end
          endcase
          q_pop_o = 1'b1;
          addr_d  = '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      addr_q       <= '0;
      chk_q        <= '0;
      chk_v_q      <= 1'b0;
      count_q      <= '0;
      free_found_q <= 1'b0;
      free_slot_q  <= '0;
      pend_v_q     <= 1'b0;
      ov_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      addr_q       <= addr_d;
      chk_q        <= chk_d;
      chk_v_q      <= chk_v_d;
      count_q      <= count_d;
      free_found_q <= free_found_d;
      free_slot_q  <= free_slot_d;
      pend_v_q     <= pend_v_d;
      ov_q         <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q <= pend_slot_d;
    pend_ent_q  <= pend_ent_d;
    ost_q       <= ost_d;
    oslot_q     <= oslot_d;
    oent_q      <= oent_d;
    ocnt_q      <= ocnt_d;
    olast_q     <= olast_d;
  end

  assign valid_o          = ov_q;
  assign status_o         = ost_q;
  assign slot_index_o     = oslot_q;
  assign out_key_head_o   = oent_q[EntW-1 -: HeadW];
  assign out_key_tail_o   = oent_q[EntW-HeadW-1 -: TailW];
  assign out_value_head_o = oent_q[KeyW-1 -: HeadW];
  assign out_value_tail_o = oent_q[TailW-1:0];
  assign removed_count_o  = ocnt_q;
  assign last_o           = olast_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !q_pop_o) else $error("pop during clear");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> ov_q && olast_q) else $error("command ended without last item");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && stall_i) |=> ov_q) else $error("stalled result dropped");

endmodule

### verif/keyed_entry_table_checker.sv
module keyed_entry_table_checker
  import ket_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [63:0] key_head_i,
  input  logic [47:0] key_tail_i,
  input  logic [63:0] value_head_i,
  input  logic [47:0] value_tail_i,
  input  logic        valid_o,
  input  logic        stall_i,
  input  logic [1:0]  status_o,
  input  logic [5:0]  slot_index_o,
  input  logic [63:0] out_key_head_o,
  input  logic [47:0] out_key_tail_o,
  input  logic [63:0] out_value_head_o,
  input  logic [47:0] out_value_tail_o,
  input  logic [6:0]  removed_count_o,
  input  logic        last_o,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e     status;
    logic [5:0]  slot;
    logic [63:0] kh;
    logic [47:0] kt;
    logic [63:0] vh;
    logic [47:0] vt;
    logic [6:0]  removed;
    logic        last;
  } table_reply_t;

  logic [63:0] key_head_mem [DEPTH];
  logic [47:0] key_tail_mem [DEPTH];
  logic [63:0] val_head_mem [DEPTH];
  logic [47:0] val_tail_mem [DEPTH];
  table_reply_t expected_replies [$];
  int fails, seen;

  assign fail_count_o   = fails;
  assign pending_o      = expected_replies.size();
  assign results_seen_o = seen;

  function automatic table_reply_t blank(status_e st);
    table_reply_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  task automatic apply_command(cmd_e cmd, logic [63:0] kh, logic [47:0] kt,
                               logic [63:0] vh, logic [47:0] vt);
    table_reply_t r;
    logic key_zero;
    int slot, n, removed;
    key_zero = (kh == '0) && (kt == '0);
    n = 0;
    removed = 0;
    slot = -1;
    case (cmd)
      CMD_INSERT: begin
        r = blank(ST_DONE);
        if (!key_zero) begin
          for (int i = 0; i < DEPTH; i++)
            if (slot < 0 && key_head_mem[i] == '0 && key_tail_mem[i] == '0) slot = i;
          if (slot < 0) r.status = ST_FULL;
          else begin
            key_head_mem[slot] = kh; key_tail_mem[slot] = kt;
            val_head_mem[slot] = vh; val_tail_mem[slot] = vt;
            r.slot = 6'(slot);
          end
        end
        r.last = 1'b1;
        expected_replies.push_back(r);
      end
      CMD_DELETE: begin
        for (int i = 0; i < DEPTH; i++)
          if (!key_zero && key_head_mem[i] == kh && key_tail_mem[i] == kt) begin
            key_head_mem[i] = '0; key_tail_mem[i] = '0;
            val_head_mem[i] = '0; val_tail_mem[i] = '0;
            removed++;
          end
        r = blank((removed != 0) ? ST_DONE : ST_NONE);
        r.removed = 7'(removed);
        r.last = 1'b1;
        expected_replies.push_back(r);
      end
      default: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (key_head_mem[i] == '0 && key_tail_mem[i] == '0) continue;
          if (cmd == CMD_LIST || (key_head_mem[i] == kh && key_tail_mem[i] == kt)) begin
            r = blank(ST_ENTRY);
            r.slot = 6'(i);
            r.kh = key_head_mem[i]; r.kt = key_tail_mem[i];
            r.vh = val_head_mem[i]; r.vt = val_tail_mem[i];
            expected_replies.push_back(r);
            n++;
          end
        end
        if (n == 0) expected_replies.push_back(blank(ST_NONE));
        expected_replies[$].last = 1'b1;
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    table_reply_t e;
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        key_head_mem[i] = '0; key_tail_mem[i] = '0;
        val_head_mem[i] = '0; val_tail_mem[i] = '0;
      end
      expected_replies.delete();
      fails = 0;
      seen = 0;
    end else begin
      if (valid_i && !stall_o)
        apply_command(cmd_e'(cmd_i), key_head_i, key_tail_i, value_head_i, value_tail_i);
      if (valid_o && !stall_i) begin
        seen++;
        if (expected_replies.size() == 0) begin
          $error("result with nothing expected, status %0d", status_o);
          fails++;
        end else begin
          e = expected_replies.pop_front();
          if (status_o != e.status) begin
            $error("status: expected %0d got %0d", e.status, status_o); fails++;
          end
          if (slot_index_o != e.slot) begin
            $error("slot_index: expected %0d got %0d", e.slot, slot_index_o); fails++;
          end
          if (out_key_head_o != e.kh) begin
            $error("out_key_head: expected %h got %h", e.kh, out_key_head_o); fails++;
          end
          if (out_key_tail_o != e.kt) begin
            $error("out_key_tail: expected %h got %h", e.kt, out_key_tail_o); fails++;
          end
          if (out_value_head_o != e.vh) begin
            $error("out_value_head: expected %h got %h", e.vh, out_value_head_o); fails++;
          end
          if (out_value_tail_o != e.vt) begin
            $error("out_value_tail: expected %h got %h", e.vt, out_value_tail_o); fails++;
          end
          if (removed_count_o != e.removed) begin
            $error("removed_count: expected %0d got %0d", e.removed, removed_count_o);
            fails++;
          end
          if (last_o != e.last) begin
            $error("last: expected %0d got %0d", e.last, last_o); fails++;
          end
        end
      end
    end
  end

endmodule

### verif/keyed_entry_table_unit_tb.sv
module keyed_entry_table_unit_tb;
  import ket_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 64;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [1:0]  cmd_i = CMD_LIST;
  logic [63:0] key_head_i = '0;
  logic [47:0] key_tail_i = '0;
  logic [63:0] value_head_i = '0;
  logic [47:0] value_tail_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [5:0]  slot_index_o;
  logic [63:0] out_key_head_o, out_value_head_o;
  logic [47:0] out_key_tail_o, out_value_tail_o;
  logic [6:0]  removed_count_o;
  logic        last_o;
  int          fail_count, pending, results_seen;

  // receiver hold-off requested by the stimulus, served by the stall process
  int          hold_off_cycles = 0;
  int          items_sent = 0;

  // a small pool of keys so that find and delete actually hit, with a few
  // duplicates to give multi-slot matches
  logic [63:0] pool_head [8];
  logic [47:0] pool_tail [8];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  keyed_entry_table_unit #(.DEPTH(DEPTH)) dut (.*);

  keyed_entry_table_checker #(.DEPTH(DEPTH)) u_checker (
    .*,
    .fail_count_o(fail_count),
    .pending_o(pending),
    .results_seen_o(results_seen)
  );

  // send one item; valid drops only for a gap, then holds until taken
  task automatic send_item(cmd_e cmd, logic [63:0] kh, logic [47:0] kt,
                           logic [63:0] vh, logic [47:0] vt, int gap);
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i      <= 1'b1;
    cmd_i        <= cmd;
    key_head_i   <= kh;
    key_tail_i   <= kt;
    value_head_i <= vh;
    value_tail_i <= vt;
    do @(posedge clk_i); while (stall_o);
    items_sent++;
  endtask

  function automatic int draw_gap();
    // roughly a third of items go back to back
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic wait_drained();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DEPTH + 8) @(posedge clk_i);
  endtask

  task automatic send_random(int count);
    cmd_e        cmd;
    int          k;
    logic [63:0] kh, vh;
    logic [47:0] kt, vt;
    for (int n = 0; n < count; n++) begin
      k  = $urandom_range(0, 7);
      kh = pool_head[k];
      kt = pool_tail[k];
      vh = {$urandom, $urandom};
      vt = 48'({$urandom, $urandom});
      case ($urandom_range(0, 9))
        0, 1, 2, 3: cmd = CMD_INSERT;
        4:          cmd = CMD_LIST;
        5, 6:       cmd = CMD_FIND;
        7:          cmd = CMD_DELETE;
        default: begin
          // noise: fresh random keys, sometimes the zero key
          cmd = cmd_e'($urandom_range(0, 3));
          kh  = ($urandom_range(0, 5) == 0) ? '0 : {$urandom, $urandom};
          kt  = ($urandom_range(0, 5) == 0) ? '0 : 48'({$urandom, $urandom});
        end
      endcase
      send_item(cmd, kh, kt, vh, vt, draw_gap());
    end
  endtask

  // result side: random stalls per item, with forced long hold-offs
  initial begin
    int wait_cycles;
    @(posedge rst_ni);
    forever begin
      if (hold_off_cycles != 0) begin
        stall_i <= 1'b1;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end
      wait_cycles = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
      if (wait_cycles != 0) begin
        stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      stall_i <= 1'b0;
      do @(posedge clk_i); while (!valid_o);
    end
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    for (int i = 0; i < 8; i++) begin
      pool_head[i] = {$urandom, $urandom};
      pool_tail[i] = 48'({$urandom, $urandom});
    end
    // keys with interior zero bytes and a head-only / tail-only key
    pool_head[6] = 64'h4100_0000_0000_0042;
    pool_tail[6] = '0;
    pool_head[7] = '0;
    pool_tail[7] = 48'h0000_0000_0001;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, zero keys, field extremes, all four commands
    send_item(CMD_LIST,   '0, '0, '0, '0, 0);
    send_item(CMD_FIND,   pool_head[0], pool_tail[0], '0, '0, 0);
    send_item(CMD_DELETE, pool_head[0], pool_tail[0], '0, '0, 0);
    send_item(CMD_INSERT, '0, '0, '1, '1, 0);
    send_item(CMD_INSERT, '1, '1, '1, '1, 0);
    send_item(CMD_INSERT, pool_head[6], pool_tail[6], '0, '0, 1);
    send_item(CMD_INSERT, pool_head[7], pool_tail[7], '1, '0, 0);
    send_item(CMD_INSERT, pool_head[0], pool_tail[0], 64'h0123_4567_89AB_CDEF,
              48'hFEDC_BA98_7654, 2);
    send_item(CMD_INSERT, pool_head[0], pool_tail[0], '0, '1, 0);
    send_item(CMD_LIST,   '0, '0, '0, '0, 0);
    send_item(CMD_FIND,   pool_head[0], pool_tail[0], '0, '0, 0);
    send_item(CMD_FIND,   '0, '0, '0, '0, 0);
    send_item(CMD_FIND,   pool_head[6], '0, '0, '0, 0);
    send_item(CMD_DELETE, '0, '0, '0, '0, 0);
    send_item(CMD_DELETE, pool_head[0], pool_tail[0], '0, '0, 0);
    send_item(CMD_DELETE, '1, '1, '0, '0, 0);
    send_item(CMD_LIST,   '0, '0, '0, '0, 0);

    // sender pause until everything is back
    wait_drained();

    // fill the table completely, then hit full, list all of it
    for (int i = 0; i < DEPTH; i++)
      send_item(CMD_INSERT, {$urandom, $urandom} | 64'h1, 48'({$urandom, $urandom}),
                {$urandom, $urandom}, 48'({$urandom, $urandom}), 0);
    send_item(CMD_INSERT, pool_head[1], pool_tail[1], '1, '1, 0);
    // long receiver hold-off while commands keep coming, so input stalls
    hold_off_cycles = 400;
    send_item(CMD_LIST, '0, '0, '0, '0, 0);
    send_item(CMD_LIST, '0, '0, '0, '0, 0);
    send_item(CMD_FIND, pool_head[1], pool_tail[1], '0, '0, 0);
    wait_drained();

    // random: the pool keys keep find and delete busy
    send_random(45);
    wait_drained();

    $display("%0d items sent, %0d results checked: empty, full and duplicate-key",
             items_sent, results_seen);
    $display("tables, zero and extreme keys, long result stalls");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/ket_pkg.sv
sv/ket_ram.sv
sv/ket_front.sv
sv/ket_back.sv
sv/keyed_entry_table_unit.sv
verif/keyed_entry_table_checker.sv
verif/keyed_entry_table_unit_tb.sv
